>>> rtl/fisn_pkg.sv
// shared types, constants and single-precision arithmetic functions
package fisn_pkg;

   localparam int NUM_STAGES = 9;

   localparam logic [31:0] MAGIC_CONST = 32'h5f3759df;
   localparam logic [31:0] FP_HALF     = 32'h3f000000;
   localparam logic [31:0] FP_ONE_P5   = 32'h3fc00000;
   localparam logic [31:0] FP_QNAN     = 32'h7fc00000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } vec_type;

   // leading zero count, 48 when the word is zero
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] lz;
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            lz = 6'(47 - i);
         end
      end
      return lz;
   endfunction

   // round to nearest even and pack, subnormal results flushed to zero
   function automatic logic [31:0] fp_pack(input logic sign, input logic signed [11:0] e,
                                           input logic [23:0] m, input logic g,
                                           input logic s);
      logic [23:0] f24;
      logic [24:0] m25;
      logic signed [11:0] en;
      if (e < 0) begin
         return {sign, 31'd0};
      end
      if (e == 0) begin
         // subnormal grid: rounding may carry up to the smallest normal
         f24 = {1'b0, m[23:1]} + 24'(m[0] & (g | s | m[1]));
         return f24[23] ? {sign, 8'd1, 23'd0} : {sign, 31'd0};
      end
      m25 = {1'b0, m} + 25'(g & (s | m[0]));
      en = m25[24] ? e + 12'sd1 : e;
      if (en >= 12'sd255) begin
         return {sign, 8'hff, 23'd0};
      end
      return {sign, en[7:0], m25[24] ? 23'd0 : m25[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic sr;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      logic [47:0] p, pn;
      logic [5:0] lz;
      logic signed [11:0] e;
      sr     = a[31] ^ b[31];
      a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         return FP_QNAN;
      end
      if (a_inf || b_inf) begin
         return {sr, 8'hff, 23'd0};
      end
      if (a_zero || b_zero) begin
         return {sr, 31'd0};
      end
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      p  = ma * mb;
      lz = lzc48(p);
      pn = p << lz;
      e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
      return fp_pack(sr, e, pn[47:24], pn[23], |pn[22:0]);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, a_inf, b_inf;
      logic [31:0] big, sml;
      logic [7:0] eb_big, eb_sml, d;
      logic [23:0] mbig, msml;
      logic [49:0] bsh;
      logic [27:0] ax, bx, sum, nrm;
      logic [5:0] lz;
      logic sub;
      logic signed [11:0] e;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         return FP_QNAN;
      end
      if (a_inf) begin
         return a;
      end
      if (b_inf) begin
         return b;
      end
      big    = (b[30:0] > a[30:0]) ? b : a;
      sml    = (b[30:0] > a[30:0]) ? a : b;
      sub    = big[31] ^ sml[31];
      eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mbig   = {(big[30:23] != 8'd0), big[22:0]};
      msml   = {(sml[30:23] != 8'd0), sml[22:0]};
      d      = eb_big - eb_sml;
      bsh    = {msml, 26'd0} >> d;
      ax     = {1'b0, mbig, 3'd0};
      bx     = {1'b0, bsh[49:24], |bsh[23:0]};
      sum    = sub ? ax - bx : ax + bx;
      if (sum == 28'd0) begin
         return {sub ? 1'b0 : big[31], 31'd0};
      end
      if (sum[27]) begin
         nrm = {1'b0, sum[27:2], sum[1] | sum[0]};
         e   = $signed({4'd0, eb_big}) + 12'sd1;
      end else begin
         lz  = lzc48({sum[26:0], 21'd0});
         nrm = sum << lz;
         e   = $signed({4'd0, eb_big}) - $signed({6'd0, lz});
      end
      return fp_pack(big[31], e, nrm[26:3], nrm[2], |nrm[1:0]);
   endfunction

endpackage

>>> rtl/fisn_len.sv
// length squared stages: three squares, then two adds
module fisn_len (
   input  logic             clock,
   input  logic [2:0]       stage_en,
   input  fisn_pkg::vec_type vec,
   output logic [31:0]      len2,
   output fisn_pkg::vec_type vec_out
);
   import fisn_pkg::*;

   logic [31:0] sq_x_ff, sq_y_ff, sq_z_ff, sum_xy_ff, sq_z1_ff, len2_ff;
   vec_type     vec_ff [0:2];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_x_ff   <= fp_mul(vec.x, vec.x);
         sq_y_ff   <= fp_mul(vec.y, vec.y);
         sq_z_ff   <= fp_mul(vec.z, vec.z);
         vec_ff[0] <= vec;
      end
      if (stage_en[1]) begin
         sum_xy_ff <= fp_add(sq_x_ff, sq_y_ff);
         sq_z1_ff  <= sq_z_ff;
         vec_ff[1] <= vec_ff[0];
      end
      if (stage_en[2]) begin
         len2_ff   <= fp_add(sum_xy_ff, sq_z1_ff);
         vec_ff[2] <= vec_ff[1];
      end
   end

   assign len2    = len2_ff;
   assign vec_out = vec_ff[2];
endmodule

>>> rtl/fisn_rsq.sv
// inverse square root stages: bit-trick estimate and one newton step
module fisn_rsq (
   input  logic             clock,
   input  logic [4:0]       stage_en,
   input  logic [31:0]      len2,
   input  fisn_pkg::vec_type vec,
   output logic [31:0]      rsq,
   output logic             zero,
   output fisn_pkg::vec_type vec_out
);
   import fisn_pkg::*;

   logic [31:0] half_ff, he_ff, t_ff, diff_ff, rsq_ff;
   logic [31:0] est_ff [0:3];
   logic [31:0] est_in, shifted;
   logic        zero_ff [0:4];
   vec_type     vec_ff [0:4];

   always_comb begin
      shifted = {len2[31], len2[31:1]};
      est_in  = MAGIC_CONST - shifted;
      if (est_in[30:23] == 8'd0) begin
         est_in = {est_in[31], 31'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         half_ff    <= fp_mul(len2, FP_HALF);
         est_ff[0]  <= est_in;
         zero_ff[0] <= (len2[30:0] == 31'd0);
         vec_ff[0]  <= vec;
      end
      if (stage_en[1]) begin
         he_ff      <= fp_mul(half_ff, est_ff[0]);
         est_ff[1]  <= est_ff[0];
         zero_ff[1] <= zero_ff[0];
         vec_ff[1]  <= vec_ff[0];
      end
      if (stage_en[2]) begin
         t_ff       <= fp_mul(he_ff, est_ff[1]);
         est_ff[2]  <= est_ff[1];
         zero_ff[2] <= zero_ff[1];
         vec_ff[2]  <= vec_ff[1];
      end
      if (stage_en[3]) begin
         // 1.5 - t as an add with the sign of t flipped
         diff_ff    <= fp_add(FP_ONE_P5, {~t_ff[31], t_ff[30:0]});
         est_ff[3]  <= est_ff[2];
         zero_ff[3] <= zero_ff[2];
         vec_ff[3]  <= vec_ff[2];
      end
      if (stage_en[4]) begin
         rsq_ff     <= fp_mul(est_ff[3], diff_ff);
         zero_ff[4] <= zero_ff[3];
         vec_ff[4]  <= vec_ff[3];
      end
   end

   assign rsq     = rsq_ff;
   assign zero    = zero_ff[4];
   assign vec_out = vec_ff[4];
endmodule

>>> rtl/fisn_scale.sv
// output stage: scale each component, or pass a zero-length vector through
module fisn_scale (
   input  logic             clock,
   input  logic             stage_en,
   input  logic [31:0]      rsq,
   input  logic             zero,
   input  fisn_pkg::vec_type vec,
   output fisn_pkg::vec_type vec_out,
   output logic             was_zero
);
   import fisn_pkg::*;

   vec_type vec_ff;
   logic    zero_ff;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         zero_ff <= zero;
         if (zero) begin
            vec_ff <= vec;
         end else begin
            vec_ff.x <= fp_mul(vec.x, rsq);
            vec_ff.y <= fp_mul(vec.y, rsq);
            vec_ff.z <= fp_mul(vec.z, rsq);
         end
      end
   end

   assign vec_out  = vec_ff;
   assign was_zero = zero_ff;
endmodule

>>> rtl/fast_inverse_sqrt_normalize_unit.sv
// top level: nine-stage normalize pipeline with per-stage handshake
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_in_x/y/z        | in
//   rsp     | rsp_valid rsp_ready rsp_out_x/y/z       | out
//           | rsp_was_zero                            |
//
// one item per cycle sustained while rsp_ready stays high
// one level of floating-point multiply or add per stage sets the stage count
// a stage takes a new item whenever it is empty or its item moves on, so
// bubbles close up while the output waits; reset only clears the valid bits
module fast_inverse_sqrt_normalize_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_in_x,
   input  logic [31:0] req_in_y,
   input  logic [31:0] req_in_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic        rsp_was_zero
);
   import fisn_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, go;
   vec_type     vec_req, vec_len, vec_rsq, vec_res;
   logic [31:0] len2, rsq;
   logic        zero;

   always_comb begin
      go[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         go[i] = !valid_ff[i] || go[i+1];
      end
      valid_in[0] = go[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = go[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign vec_req = '{x: req_in_x, y: req_in_y, z: req_in_z};

   fisn_len u_len (
      .clock    (clock),
      .stage_en (go[2:0]),
      .vec      (vec_req),
      .len2     (len2),
      .vec_out  (vec_len)
   );

   fisn_rsq u_rsq (
      .clock    (clock),
      .stage_en (go[7:3]),
      .len2     (len2),
      .vec      (vec_len),
      .rsq      (rsq),
      .zero     (zero),
      .vec_out  (vec_rsq)
   );

   fisn_scale u_scale (
      .clock    (clock),
      .stage_en (go[8]),
      .rsq      (rsq),
      .zero     (zero),
      .vec      (vec_rsq),
      .vec_out  (vec_res),
      .was_zero (rsp_was_zero)
   );

   assign req_ready = go[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_out_x = vec_res.x;
   assign rsp_out_y = vec_res.y;
   assign rsp_out_z = vec_res.z;

`ifndef SYNTHESIS
   // an accepted item always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted item missing from first stage");

   // a held first stage keeps its item
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !go[0] |=> valid_ff[0])
      else $error("first stage lost a held item");

   // a zero length needs every component below 2**-63
   a_zero_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_zero |-> rsp_out_x[30:29] == 2'b00 &&
         rsp_out_y[30:29] == 2'b00 && rsp_out_z[30:29] == 2'b00)
      else $error("zero-length flag on a large vector");
`endif
endmodule

>>> sim/fisn_checker.sv
// checker: predicts each normalized vector and compares it with the unit's results
module fisn_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_in_x,
   input  logic [31:0] req_in_y,
   input  logic [31:0] req_in_z,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_out_x,
   input  logic [31:0] rsp_out_y,
   input  logic [31:0] rsp_out_z,
   input  logic        rsp_was_zero,
   output int          fail_count,
   output int          pending
);
   import fisn_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        was_zero;
   } norm_result_type;

   norm_result_type norm_queue[$];

   // single pattern to double, subnormal inputs kept as given
   function automatic real sp_to_real(input logic [31:0] b);
      logic [10:0] de;
      real r;
      if (b[30:23] == 8'hff) begin
         return $bitstoreal({b[31], 11'h7ff, (b[22:0] != 23'd0), 51'd0});
      end
      if (b[30:23] == 8'd0) begin
         if (b[22:0] == 23'd0) begin
            return $bitstoreal({b[31], 63'd0});
         end
         r = $itor(b[22:0]) * (2.0 ** (-149));
         return b[31] ? -r : r;
      end
      de = 11'(b[30:23]) + 11'd896;
      return $bitstoreal({b[31], de, b[22:0], 29'd0});
   endfunction

   // double to single with nearest-even rounding, subnormals flushed, nan canonical
   function automatic logic [31:0] real_to_sp(input real r);
      logic [63:0] d;
      logic [52:0] m;
      logic [24:0] m25;
      logic [23:0] sub24;
      int e;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff) begin
         return (d[51:0] != 52'd0) ? FP_QNAN : {d[63], 8'hff, 23'd0};
      end
      if (d[62:52] == 11'd0) begin
         return {d[63], 31'd0};
      end
      e = int'(d[62:52]) - 896;
      m = {1'b1, d[51:0]};
      if (e >= 1) begin
         m25 = {1'b0, m[52:29]} + 25'(m[28] & ((|m[27:0]) | m[29]));
         if (m25[24]) begin
            e = e + 1;
         end
         if (e >= 255) begin
            return {d[63], 8'hff, 23'd0};
         end
         return {d[63], 8'(e), m25[24] ? 23'd0 : m25[22:0]};
      end
      if (e == 0) begin
         // just under the smallest normal: only a round-up survives the flush
         sub24 = {1'b0, m[52:30]} + 24'(m[29] & ((|m[28:0]) | m[30]));
         return sub24[23] ? {d[63], 8'd1, 23'd0} : {d[63], 31'd0};
      end
      return {d[63], 31'd0};
   endfunction

   // sums and products of singles are exact enough in double for one final rounding
   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) * sp_to_real(b));
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) + sp_to_real(b));
   endfunction

   function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) - sp_to_real(b));
   endfunction

   function automatic norm_result_type normalize_vector(input logic [31:0] x,
                                                        input logic [31:0] y,
                                                        input logic [31:0] z);
      norm_result_type res;
      logic [31:0] len2, half, est, shifted, t, scale;
      len2 = sp_add(sp_add(sp_mul(x, x), sp_mul(y, y)), sp_mul(z, z));
      if (len2[30:0] == 31'd0) begin
         res = '{x: x, y: y, z: z, was_zero: 1'b1};
         return res;
      end
      half    = sp_mul(len2, FP_HALF);
      shifted = {len2[31], len2[31:1]};
      est     = MAGIC_CONST - shifted;
      if (est[30:23] == 8'd0) begin
         est = {est[31], 31'd0};
      end
      t     = sp_mul(sp_mul(half, est), est);
      scale = sp_mul(est, sp_sub(FP_ONE_P5, t));
      res = '{x: sp_mul(x, scale), y: sp_mul(y, scale), z: sp_mul(z, scale), was_zero: 1'b0};
      return res;
   endfunction

   assign pending = norm_queue.size();

   always @(posedge clock) begin
      norm_result_type exp_res;
      if (reset) begin
         norm_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            norm_queue = {norm_queue, normalize_vector(req_in_x, req_in_y, req_in_z)};
         end
         if (rsp_valid && rsp_ready) begin
            if (norm_queue.size() == 0) begin
               $display("%0t: result with no item waiting: %h %h %h %b", $time,
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_was_zero);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = norm_queue.pop_front();
               if (rsp_out_x !== exp_res.x || rsp_out_y !== exp_res.y ||
                   rsp_out_z !== exp_res.z || rsp_was_zero !== exp_res.was_zero) begin
                  $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                           exp_res.x, exp_res.y, exp_res.z, exp_res.was_zero,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_was_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> sim/testbench.sv
// testbench top: drives vectors into the normalize unit and gives the verdict
module testbench;
   import fisn_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_in_x = '0;
   logic [31:0] req_in_y = '0;
   logic [31:0] req_in_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic        rsp_was_zero;
   int          fail_count;
   int          pending;
   int          send_idle = 18;
   int          recv_idle = 56;
   logic        hold_req = 1'b0;
   logic        hold_off = 1'b0;

   fast_inverse_sqrt_normalize_unit uut (.*);
   fisn_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, ready held low throughout while held off
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one long hold-off while the sender keeps going
   initial begin
      wait (hold_req);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_vector(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      logic taken;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= x;
      req_in_y  <= y;
      req_in_z  <= z;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic logic [31:0] pick_special();
      case ($urandom_range(6))
         0: return 32'h00000000;
         1: return 32'h80000000;
         2: return 32'h7f800000;
         3: return 32'hff800000;
         4: return {1'($urandom_range(1)), 8'hff, 23'($urandom_range(1, 23'h7fffff))};
         5: return {1'($urandom_range(1)), 8'h00, 23'($urandom_range(1, 23'h7fffff))};
         default: return {1'($urandom_range(1)), 31'h7f7fffff};
      endcase
   endfunction

   // mostly well-scaled components, with tiny, huge, raw and special ones mixed in
   function automatic logic [31:0] pick_component();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return {1'($urandom), 8'($urandom_range(97, 157)), 23'($urandom)};
      end
      if (roll < 78) begin
         return $urandom;
      end
      if (roll < 88) begin
         return {1'($urandom), 8'($urandom_range(0, 70)), 23'($urandom)};
      end
      if (roll < 94) begin
         return {1'($urandom), 8'($urandom_range(180, 254)), 23'($urandom)};
      end
      return pick_special();
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_vector(pick_component(), pick_component(), pick_component());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed items
      send_vector(32'h00000000, 32'h00000000, 32'h00000000);
      send_vector(32'h80000000, 32'h80000000, 32'h80000000);
      send_vector(32'h3f800000, 32'h00000000, 32'h00000000);
      send_vector(32'h3f800000, 32'h3f800000, 32'h3f800000);
      send_vector(32'hc0400000, 32'h40800000, 32'h00000000);
      // squares flush to zero, vector passes unchanged
      send_vector(32'h00000001, 32'h807fffff, 32'h1e000000);
      send_vector(32'h00800000, 32'h80800000, 32'h00400000);
      // length squared overflows to infinity
      send_vector(32'h7f7fffff, 32'hff7fffff, 32'h3f800000);
      send_vector(32'h7f800000, 32'h3f800000, 32'h3f800000);
      send_vector(32'hff800000, 32'h7f800000, 32'h00000000);
      send_vector(32'h7fc00000, 32'h3f800000, 32'h3f800000);
      send_vector(32'hffffffff, 32'h00000000, 32'h00000000);
      send_vector(32'h7f800001, 32'h00000000, 32'h00000000);
      send_vector(32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_vector(32'h20000000, 32'h20000000, 32'h20000000);
      send_vector(32'h1f800000, 32'h00000000, 32'h00000000);
      send_vector(32'h5f000000, 32'hdf000000, 32'h5f000000);
      send_vector(32'h00000000, 32'h00000000, 32'h00000001);
      send_vector(32'h00000000, 32'hbf800000, 32'h00000000);
      send_vector(32'h55555555, 32'haaaaaaaa, 32'h33333333);
      send_random(230);
      send_idle = 56;
      recv_idle = 18;
      send_random(230);
      send_idle = 0;
      recv_idle = 0;
      hold_req <= 1'b1;
      send_random(240);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS fast_inverse_sqrt_normalize_unit");
      end else begin
         $display("FAIL fast_inverse_sqrt_normalize_unit");
      end
      $finish;
   end

   initial begin
      #1600000;
      $display("FAIL fast_inverse_sqrt_normalize_unit");
      $finish;
   end

endmodule
